### sv/esr_pkg.sv
// Shared types and constants for the EMA smoothing and rescale block.
// Used by esr_div and ema_smooth_and_rescale; depends on nothing else.
package esr_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int DATA_W          = 16;
	localparam int ALPHA_W         = 17;
	localparam int ACC_W           = 32;
	localparam int FRAC_W          = 16;
	localparam int PROD_W          = ALPHA_W + ACC_W;
	localparam int MAG_W           = PROD_W - FRAC_W + 1;
	localparam int NEXT_W          = ACC_W + 2;
	localparam int CFG_IDX_W       = 2;

	// Divider retires two quotient bits per cycle
	localparam int DIV_BITS_PER_CYC = 2;
	localparam int DIV_ITER         = ACC_W / DIV_BITS_PER_CYC;
	localparam int DIV_CNT_W        = $clog2(DIV_ITER);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA      = 2'd0,
		REG_ANALOG_MAX = 2'd1,
		REG_MAX_OUTPUT = 2'd2,
		REG_ENABLE     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic              start;
		logic [ACC_W-1:0]  num;
		logic [DATA_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quo;
	} div_rsp_t;

endpackage

### sv/esr_div.sv
// Iterative restoring divider: 32-bit dividend by 16-bit divisor, 2 bits per cycle.
// Returns the low 16 quotient bits. Depends on esr_pkg.
module esr_div
	import esr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0]     num_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    den_q;

	logic [DATA_W:0]   r1, r2;
	logic              ge1, ge2;
	logic [DATA_W-1:0] rem1, rem2;

	always_comb begin
		r1   = {rem_q, num_q[ACC_W-1]};
		ge1  = r1 >= {1'b0, den_q};
		rem1 = ge1 ? DATA_W'(r1 - {1'b0, den_q}) : r1[DATA_W-1:0];
		r2   = {rem1, num_q[ACC_W-2]};
		ge2  = r2 >= {1'b0, den_q};
		rem2 = ge2 ? DATA_W'(r2 - {1'b0, den_q}) : r2[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == DIV_CNT_W'(DIV_ITER - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_ITER - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Quotient bits shift into the low end as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[ACC_W-3:0], ge1, ge2};
			rem_q <= rem2;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = num_q[DATA_W-1:0];

endmodule

### sv/ema_smooth_and_rescale.sv
// Top level: Q16.16 exponential moving average with a rounded rescale to 0..max_output.
// Sequencer, shared 17x32 multiplier and config registers; uses esr_pkg and esr_div.
//
//  channel | dir | handshake              | payload
//  s_*     | in  | s_tvalid / s_tready    | s_tdata[15:0] raw_sample
//  m_*     | out | m_tvalid / m_tready    | m_tdata scaled/smoothed, m_tuser value_changed
//  cfg_*   | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (register write)
//
// Disabled, a sample goes straight to output; enabled, it runs the difference,
// multiply, magnitude, accumulate and smooth steps, and the rescale and divider
// only when the rounded value changes. The multiplier is reused for the EMA step and rescale.
// Reset is asynchronous, active low; all config returns to its defaults.
// The result waits in an output register, so a stalled m_tready only holds
// the sequencer at its final step. cfg_ready is always high.
module ema_smooth_and_rescale
	import esr_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_W-1:0]    s_tdata,   // [15:0] raw_sample
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [2*DATA_W-1:0]  m_tdata,   // [15:0] scaled_value, [31:16] smoothed_value
	output logic                 m_tuser,   // [0] value_changed
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ALPHA_W-1:0]   cfg_data
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_DIF  = 10'b0000000010,
		ST_MUL  = 10'b0000000100,
		ST_MAG  = 10'b0000001000,
		ST_ACC  = 10'b0000010000,
		ST_SMO  = 10'b0000100000,
		ST_SCL  = 10'b0001000000,
		ST_DST  = 10'b0010000000,
		ST_DIV  = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [ALPHA_W-1:0] alpha_q;
	logic [DATA_W-1:0]  amax_q;
	logic [DATA_W-1:0]  maxout_q;
	logic               enable_q;

	logic [ACC_W-1:0]  acc_q;
	logic              seeded_q;
	logic [DATA_W-1:0] last_smoothed_q;
	logic [DATA_W-1:0] last_scaled_q;
	logic              changed_q;

	logic                   m_tvalid_q;
	logic [2*DATA_W-1:0]    m_tdata_q;
	logic                   m_tuser_q;

	logic [SAMPLE_BITS-1:0] raw_q;
	logic [ACC_W-1:0]       diff_q;
	logic                   up_q;
	logic [PROD_W-1:0]      prod_q;
	logic [MAG_W-1:0]       mag_q;
	logic [DATA_W-1:0]      sm_q;

	logic                 accept;
	logic [ACC_W-1:0]     raw_w;
	logic [ACC_W-1:0]     seed_w;
	logic [ACC_W-1:0]     limit_w;
	logic [ALPHA_W-1:0]   mul_a;
	logic [ACC_W-1:0]     mul_b;
	logic [PROD_W-1:0]    mul_p;
	logic [PROD_W:0]      prod_rnd;
	logic [NEXT_W-1:0]    next_w;
	logic [ACC_W-1:0]     acc_next;
	logic [ACC_W:0]       sm_sum;
	logic [DATA_W-1:0]    sm_w;
	logic                 out_free;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	assign raw_w   = ACC_W'(raw_q) << FRAC_W;
	assign seed_w  = ACC_W'(s_tdata[SAMPLE_BITS-1:0]) << FRAC_W;
	assign limit_w = {amax_q, {FRAC_W{1'b0}}};

	// Shared multiplier: EMA step first, rescale product later
	always_comb begin
		if (state_q == ST_MUL) begin
			mul_a = alpha_q;
			mul_b = diff_q;
		end else begin
			mul_a = ALPHA_W'(sm_q);
			mul_b = ACC_W'(maxout_q);
		end
		mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// Round the downward step away from zero so the average settles
	assign prod_rnd = {1'b0, prod_q} + (PROD_W+1)'((1 << FRAC_W) - 1);

	always_comb begin
		if (up_q) begin
			next_w = NEXT_W'(acc_q) + NEXT_W'(mag_q);
		end else if (NEXT_W'(mag_q) > NEXT_W'(acc_q)) begin
			next_w = '0;
		end else begin
			next_w = NEXT_W'(acc_q) - NEXT_W'(mag_q);
		end
		acc_next = (next_w > NEXT_W'(limit_w)) ? limit_w : next_w[ACC_W-1:0];
	end

	assign sm_sum = {1'b0, acc_q} + (ACC_W+1)'(1 << (FRAC_W-1));
	assign sm_w   = sm_sum[ACC_W-1:FRAC_W];

	assign div_req.start = (state_q == ST_DST);
	assign div_req.num   = prod_q[ACC_W-1:0] + ACC_W'(amax_q >> 1);
	assign div_req.den   = amax_q;

	esr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			alpha_q         <= ALPHA_W'(65536);
			amax_q          <= DATA_W'(1023);
			maxout_q        <= DATA_W'(1023);
			enable_q        <= 1'b1;
			acc_q           <= '0;
			seeded_q        <= 1'b0;
			last_smoothed_q <= '0;
			last_scaled_q   <= '0;
			changed_q       <= 1'b0;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ALPHA:      alpha_q <= cfg_data;
					REG_ANALOG_MAX: begin
						// drop a zero divisor, keep the old one
						if (cfg_data[DATA_W-1:0] != '0) amax_q <= cfg_data[DATA_W-1:0];
					end
					REG_MAX_OUTPUT: maxout_q <= cfg_data[DATA_W-1:0];
					REG_ENABLE:     enable_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (state_q == ST_OUT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						changed_q <= 1'b0;
						seeded_q  <= 1'b1;
						if (!seeded_q) acc_q <= seed_w;
						state_q <= enable_q ? ST_DIF : ST_OUT;
					end
				end
				ST_DIF: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_MAG;
				ST_MAG: state_q <= ST_ACC;
				ST_ACC: begin
					acc_q   <= acc_next;
					state_q <= ST_SMO;
				end
				ST_SMO: begin
					state_q <= (sm_w != last_smoothed_q) ? ST_SCL : ST_OUT;
				end
				ST_SCL: state_q <= ST_DST;
				ST_DST: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_rsp.done) begin
						last_smoothed_q <= sm_q;
						if (div_rsp.quo != last_scaled_q) begin
							last_scaled_q <= div_rsp.quo;
							changed_q     <= 1'b1;
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) raw_q <= s_tdata[SAMPLE_BITS-1:0];
		if (state_q == ST_DIF) begin
			up_q   <= raw_w >= acc_q;
			diff_q <= (raw_w >= acc_q) ? raw_w - acc_q : acc_q - raw_w;
		end
		if (state_q == ST_MUL || state_q == ST_SCL) prod_q <= mul_p;
		if (state_q == ST_MAG) begin
			mag_q <= up_q ? MAG_W'(prod_q[PROD_W-1:FRAC_W]) : prod_rnd[PROD_W:FRAC_W];
		end
		if (state_q == ST_SMO) sm_q <= sm_w;
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= {last_smoothed_q, last_scaled_q};
			m_tuser_q <= changed_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// A new sample never enters back to back with the previous one
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("sample accepted while sequencer busy");

	// The accumulator update lands within the clamp bound unless analog_max is written in the same cycle
	a_acc_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && !(cfg_valid && cfg_index == REG_ANALOG_MAX))
		|=> acc_q <= {amax_q, {FRAC_W{1'b0}}})
		else $error("accumulator above analog_max bound");

	// Divider results only arrive while the sequencer waits for them
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside its wait state");

endmodule

### tb/sv/ema_smooth_and_rescale_test.sv
`timescale 1ns / 1ps
// Self-checking bench for ema_smooth_and_rescale: streams raw samples under several
// register settings and idle patterns, predicting each smoothed/rescaled result.
// Depends on esr_pkg and the ema_smooth_and_rescale RTL.
module ema_smooth_and_rescale_test;
	import esr_pkg::*;

	localparam int STALL_LIMIT = 2000;  // cycles without any transaction
	localparam int SETTLE      = 30;    // longer than one sample's latency
	localparam int PHASES      = 9;

	typedef struct packed {
		logic [DATA_W-1:0] scaled;
		logic [DATA_W-1:0] smoothed;
		logic              changed;
	} ema_result_t;

	// Tracks accepted samples, predicts the block's output and checks it in order.
	class ema_scoreboard;
		bit [ALPHA_W-1:0] alpha;
		bit [DATA_W-1:0]  amax;
		bit [DATA_W-1:0]  mout;
		bit               en;
		bit [ACC_W-1:0]   acc;
		bit               seeded;
		bit [DATA_W-1:0]  last_sm;
		bit [DATA_W-1:0]  last_sc;
		ema_result_t      expected_q[$];
		int               errors;

		function new();
			alpha   = 17'h10000;
			amax    = 16'd1023;
			mout    = 16'd1023;
			en      = 1'b1;
			acc     = '0;
			seeded  = 1'b0;
			last_sm = '0;
			last_sc = '0;
			errors  = 0;
		endfunction

		function void write_reg(input reg_idx_t idx, input bit [ALPHA_W-1:0] data);
			case (idx)
				REG_ALPHA: alpha = data;
				REG_ANALOG_MAX: begin
					// a zero divisor is refused, the old bound stays
					if (data[15:0] != '0)
						amax = data[15:0];
				end
				REG_MAX_OUTPUT: mout = data[15:0];
				REG_ENABLE: en = data[0];
				default: ;
			endcase
		endfunction

		function void note_sample(input bit [DATA_W-1:0] raw);
			bit [63:0]       raw_q;
			bit [63:0]       limit;
			bit [63:0]       prod;
			bit [63:0]       mag;
			bit [63:0]       nxt;
			bit [63:0]       num;
			bit [DATA_W-1:0] sm;
			bit [DATA_W-1:0] mapped;
			bit              chg;
			chg = 1'b0;
			if (!seeded) begin
				acc    = {raw, 16'h0000};
				seeded = 1'b1;
			end
			if (en) begin
				raw_q = {32'h0, raw, 16'h0000};
				limit = {32'h0, amax, 16'h0000};
				if (raw_q >= 64'(acc)) begin
					prod = 64'(alpha) * (raw_q - 64'(acc));
					nxt  = 64'(acc) + (prod >> 16);
				end else begin
					// round the downward step away from zero, floor of the signed step
					prod = 64'(alpha) * (64'(acc) - raw_q);
					mag  = (prod + 64'd65535) >> 16;
					nxt  = (mag > 64'(acc)) ? 64'd0 : 64'(acc) - mag;
				end
				if (nxt > limit)
					nxt = limit;
				acc = nxt[31:0];
				nxt = 64'(acc) + 64'd32768;
				sm  = nxt[31:16];
				if (sm != last_sm) begin
					num     = 64'(sm) * 64'(mout) + 64'(amax >> 1);
					num     = num / 64'(amax);
					mapped  = num[15:0];
					last_sm = sm;
					if (mapped != last_sc) begin
						last_sc = mapped;
						chg     = 1'b1;
					end
				end
			end
			expected_q.push_back('{scaled: last_sc, smoothed: last_sm, changed: chg});
		endfunction

		function void check_result(input logic [2*DATA_W-1:0] tdata, input logic tuser);
			ema_result_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result tdata=%h tuser=%b", $time, tdata, tuser);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (tdata[15:0] !== exp_r.scaled) begin
				$display("%0t: scaled_value expected %0d actual %0d",
					$time, exp_r.scaled, tdata[15:0]);
				errors++;
			end
			if (tdata[31:16] !== exp_r.smoothed) begin
				$display("%0t: smoothed_value expected %0d actual %0d",
					$time, exp_r.smoothed, tdata[31:16]);
				errors++;
			end
			if (tuser !== exp_r.changed) begin
				$display("%0t: value_changed expected %0d actual %0d",
					$time, exp_r.changed, tuser);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [2*DATA_W-1:0]   m_tdata;   // [15:0] scaled_value, [31:16] smoothed_value
	logic                  m_tuser;   // [0] value_changed
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ALPHA_W-1:0]    cfg_data = '0;

	ema_scoreboard sb;
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_stall_pct = 0;
	int unsigned   prev_raw = 0;
	int            quiet_cycles = 0;

	ema_smooth_and_rescale dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_sample(input bit [DATA_W-1:0] raw);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= raw;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(raw);
		prev_raw = 32'(raw);
	endtask

	// Hold off the sender until every predicted result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Keeps cfg_valid high so back-to-back writes need no drop in between.
	task automatic write_reg(input reg_idx_t idx, input bit [ALPHA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic set_config(input bit [ALPHA_W-1:0] alpha, input bit [DATA_W-1:0] amax,
			input bit [DATA_W-1:0] mout, input bit en);
		drain_results();
		write_reg(REG_ALPHA, alpha);
		// unused upper data bits carry junk, the block must mask them
		write_reg(REG_ANALOG_MAX, {1'($urandom_range(1)), amax});
		write_reg(REG_MAX_OUTPUT, {1'($urandom_range(1)), mout});
		write_reg(REG_ENABLE, {16'($urandom), en});
		cfg_valid <= 1'b0;
	endtask

	// Mostly a slow wander like a turned knob, some jumps within range, some out of range.
	function automatic bit [DATA_W-1:0] pick_sample(input int unsigned top);
		int unsigned r;
		int          span;
		int          v;
		r = $urandom_range(99);
		if (r < 60) begin
			span = int'(top / 64) + 1;
			v = int'(prev_raw) + int'($urandom_range(2 * span)) - span;
			if (v < 0)
				v = 0;
			if (v > int'(top))
				v = int'(top);
		end else if (r < 85) begin
			v = int'($urandom_range(top));
		end else begin
			v = int'($urandom_range(16'hFFFF));
		end
		return 16'(v);
	endfunction

	task automatic run_phase(input int idx);
		bit [ALPHA_W-1:0] alpha;
		bit [DATA_W-1:0]  amax;
		bit [DATA_W-1:0]  mout;
		bit               en;
		int               n;
		alpha = 17'($urandom_range(1, 65536));
		amax  = 16'($urandom_range(1, 65535));
		mout  = 16'($urandom_range(65535));
		en    = 1'b1;
		n     = 260;
		case (idx)
			0: begin
				amax = 16'd1023;
				mout = 16'd1023;
			end
			1: alpha = 17'h10000;
			2: begin
				alpha = 17'($urandom_range(65537, 131071));
				mout  = 16'hFFFF;
			end
			3: begin
				alpha = 17'd1;
				amax  = 16'hFFFF;
			end
			4: begin
				amax = 16'($urandom_range(1, 255));
				mout = 16'd0;
			end
			5: begin
				alpha = 17'd0;
				n     = 60;
			end
			6: begin
				en = 1'b0;
				n  = 60;
			end
			7: alpha = 17'($urandom_range(131071));
			default: begin
				amax = 16'($urandom_range(1, 4095));
			end
		endcase
		set_config(alpha, amax, mout, en);
		case (idx % 4)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 85;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 85;
			end
			default: begin
				send_idle_pct  = 14;
				recv_stall_pct = 14;
			end
		endcase
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				drain_results();
			send_sample(pick_sample(amax));
		end
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: seeding, saturation above analog max, bit patterns
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'd512);
		send_sample(16'd1023);
		send_sample(16'h5555);
		send_sample(16'hAAAA);

		// Zero alpha: the accumulator holds
		set_config(17'd0, 16'd1023, 16'd1023, 1'b1);
		send_sample(16'd0);
		send_sample(16'd700);

		// Alpha past unity overshoots, saturates at both ends; output range empty
		set_config(17'h1FFFF, 16'hFFFF, 16'd0, 1'b1);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		send_sample(16'h8000);

		// Smallest bound with the widest output range
		set_config(17'd1, 16'd1, 16'hFFFF, 1'b1);
		send_sample(16'd1);
		send_sample(16'd0);

		// Zero written as analog max is dropped
		drain_results();
		write_reg(REG_ANALOG_MAX, 17'd0);
		cfg_valid <= 1'b0;
		send_sample(16'd1);

		// Disabled: results repeat the last values
		set_config(17'h10000, 16'd1023, 16'd1023, 1'b0);
		send_sample(16'd300);
		send_sample(16'hFFFF);

		set_config(17'h08000, 16'd1023, 16'd1023, 1'b1);
		send_sample(16'd0);
		send_sample(16'd1023);

		for (int p = 0; p < PHASES; p++)
			run_phase(p);

		drain_results();
		repeat (50) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
